// ===== hdl/phbw_pkg.sv =====
// Package of shared types and constants for the processed-height bitmap window.
package phbw_pkg;

  localparam int unsigned WINDOW_WORDS_DEF = 64;
  localparam int unsigned HEIGHT_W = 64;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned WORD_IDX_W = 58;
  localparam int unsigned TOP_W = 59;
  localparam int unsigned GAP_W = 16;
  localparam int unsigned CNT_W = 17;

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_GAP     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DISP,
    ST_REC_CLR,
    ST_REC_RD,
    ST_REC_WR,
    ST_QRY_RD,
    ST_GAP,
    ST_GAP_FILL
  } state_e;

  // Result of probing one height against the window and the cached word.
  typedef struct packed {
    logic in_win;
    logic hit;
    logic bit_val;
  } probe_t;

endpackage

// ===== hdl/phbw_ram.sv =====
// Generic single-port RAM with registered read data.
module phbw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/phbw_probe.sv =====
// Bit probe unit: window check and cached-word lookup for one height.
module phbw_probe (
  input  logic [phbw_pkg::HEIGHT_W-1:0]   pos_i,
  input  logic [phbw_pkg::WORD_IDX_W-1:0] base_i,
  input  logic [phbw_pkg::TOP_W-1:0]      top_i,
  input  logic                            cache_valid_i,
  input  logic [phbw_pkg::WORD_IDX_W-1:0] cache_tag_i,
  input  logic [phbw_pkg::WORD_W-1:0]     cache_word_i,
  output phbw_pkg::probe_t                probe_o
);

  logic [phbw_pkg::WORD_IDX_W-1:0] word;

  assign word = pos_i[phbw_pkg::HEIGHT_W-1:6];

  always_comb begin
    probe_o.in_win  = (word >= base_i) && ({1'b0, word} < top_i);
    probe_o.hit     = cache_valid_i && (cache_tag_i == word);
    probe_o.bit_val = probe_o.in_win && cache_word_i[pos_i[5:0]];
  end

endmodule

// ===== hdl/processed_height_bitmap_window.sv =====
// Top level of the processed-height bitmap window tracker.
//
// The block records processed heights in a sliding window of 64-bit bitmap
// words kept in one RAM, and answers queries and latest-gap searches. A
// command beat is taken when start_i is high and busy_o is low; exactly one
// result beat follows, shown for one cycle with strobe_o high, and the
// receiver cannot stall it. After reset the block is busy for one pass that
// clears the RAM, one entry a cycle. A query reads its word from the RAM
// unless the height is out of the recorded range or outside the window. A
// record that is not refused first clears each new bitmap word that it
// brings into the window (one up to WINDOW_WORDS), then reads and writes
// back its word. The gap search is done by one bit probe unit that tests
// one height per cycle, except that it holds while it loads a bitmap word
// from the RAM; the scan is bounded by the recorded run above the gap, by
// max_gap_i and by the lowest recorded height.
module processed_height_bitmap_window #(
  parameter int unsigned WINDOW_WORDS = phbw_pkg::WINDOW_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     op_i,
  input  logic [phbw_pkg::HEIGHT_W-1:0]  height_i,
  input  logic [phbw_pkg::GAP_W-1:0]     max_gap_i,
  output logic                           strobe_o,
  output logic                           recorded_o,
  output logic                           found_o,
  output logic [phbw_pkg::HEIGHT_W-1:0]  gap_lo_o,
  output logic [phbw_pkg::HEIGHT_W-1:0]  gap_hi_o,
  output logic                           overflow_o
);

  // Word w lives in slot w mod DEPTH; DEPTH is a power of two no smaller than
  // the window, so the slots of the words in the window never collide.
  localparam int unsigned AW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned IW = phbw_pkg::WORD_IDX_W;
  localparam int unsigned TW = phbw_pkg::TOP_W;
  localparam int unsigned HW = phbw_pkg::HEIGHT_W;
  localparam logic [TW-1:0] WIN = TW'(WINDOW_WORDS);

  phbw_pkg::state_e state_q, state_d;

  logic [1:0]                  op_q, op_d;
  logic [HW-1:0]               height_q, height_d;
  logic [phbw_pkg::GAP_W-1:0]  max_gap_q, max_gap_d;

  logic [IW-1:0] base_q, base_d;
  logic [TW-1:0] top_q, top_d;
  logic [HW-1:0] lowest_q, lowest_d;
  logic [HW-1:0] highest_q, highest_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] kend_q, kend_d;

  logic [HW-1:0]              pos_q, pos_d;
  logic [HW-1:0]              floor_q, floor_d;
  logic [HW-1:0]              right_q, right_d;
  logic [phbw_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       phase2_q, phase2_d;
  logic                       cache_valid_q, cache_valid_d;
  logic [IW-1:0]              cache_tag_q, cache_tag_d;
  logic [phbw_pkg::WORD_W-1:0] cache_word_q, cache_word_d;

  logic          strobe_q, strobe_d;
  logic          recorded_q, recorded_d;
  logic          found_q, found_d;
  logic [HW-1:0] left_q, left_d;
  logic [HW-1:0] right_out_q, right_out_d;
  logic          overflow_q, overflow_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [phbw_pkg::WORD_W-1:0] ram_wdata;
  logic [phbw_pkg::WORD_W-1:0] ram_rdata;

  logic [HW-1:0]    probe_pos;
  phbw_pkg::probe_t probe;

  logic [IW-1:0] w;
  logic [TW-1:0] wp1;
  logic [IW-1:0] new_base;
  logic [IW-1:0] start_word;
  logic [HW-1:0] floor_c;
  logic          stop_gap;
  logic          bit_now;

  assign w   = height_q[HW-1:6];
  assign wp1 = {1'b0, w} + TW'(1);

  always_comb begin
    new_base = base_q;
    if ((wp1 - {1'b0, base_q}) > WIN) begin
      new_base = IW'(wp1 - WIN);
    end
    start_word = (top_q > {1'b0, new_base}) ? top_q[IW-1:0] : new_base;
    floor_c = (lowest_q > HW'(1)) ? lowest_q : HW'(1);
  end

  assign probe_pos = (state_q == phbw_pkg::ST_GAP) ? pos_q : height_q;

  phbw_probe u_probe (
    .pos_i         (probe_pos),
    .base_i        (base_q),
    .top_i         (top_q),
    .cache_valid_i (cache_valid_q),
    .cache_tag_i   (cache_tag_q),
    .cache_word_i  (cache_word_q),
    .probe_o       (probe)
  );

  phbw_ram #(
    .WIDTH (phbw_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // The RAM port is shared by the clearing pass, word clears, the
  // read-modify-write of a record and the fetches of query and gap search.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (state_q)
      phbw_pkg::ST_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      phbw_pkg::ST_REC_CLR: begin
        ram_we   = 1'b1;
        ram_addr = k_q[AW-1:0];
      end
      phbw_pkg::ST_REC_WR: begin
        ram_we    = 1'b1;
        ram_addr  = w[AW-1:0];
        ram_wdata = ram_rdata | (phbw_pkg::WORD_W'(1) << height_q[5:0]);
      end
      phbw_pkg::ST_GAP: begin
        ram_addr = pos_q[AW+5:6];
      end
      default: begin
        ram_addr = w[AW-1:0];
      end
    endcase
  end

  assign stop_gap = phase2_q && (cnt_q >= {1'b0, max_gap_q});
  assign bit_now  = probe.bit_val;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    height_d      = height_q;
    max_gap_d     = max_gap_q;
    base_d        = base_q;
    top_d         = top_q;
    lowest_d      = lowest_q;
    highest_d     = highest_q;
    clr_d         = clr_q;
    k_d           = k_q;
    kend_d        = kend_q;
    pos_d         = pos_q;
    floor_d       = floor_q;
    right_d       = right_q;
    cnt_d         = cnt_q;
    phase2_d      = phase2_q;
    cache_valid_d = cache_valid_q;
    cache_tag_d   = cache_tag_q;
    cache_word_d  = cache_word_q;
    strobe_d      = 1'b0;
    recorded_d    = recorded_q;
    found_d       = found_q;
    left_d        = left_q;
    right_out_d   = right_out_q;
    overflow_d    = overflow_q;

    unique case (state_q)
      phbw_pkg::ST_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = phbw_pkg::ST_IDLE;
        end
      end

      phbw_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d      = op_i;
          height_d  = height_i;
          max_gap_d = max_gap_i;
          state_d   = phbw_pkg::ST_DISP;
        end
      end

      phbw_pkg::ST_DISP: begin
        // Each result beat clears the fields its command does not produce.
        recorded_d  = 1'b0;
        found_d     = 1'b0;
        left_d      = '0;
        right_out_d = '0;
        overflow_d  = 1'b0;
        unique case (phbw_pkg::op_e'(op_q))
          phbw_pkg::OP_RECORD: begin
            if (w < base_q) begin
              if ((top_q - {1'b0, w}) > WIN) begin
                overflow_d = 1'b1;
                strobe_d   = 1'b1;
                state_d    = phbw_pkg::ST_IDLE;
              end else begin
                k_d     = w;
                kend_d  = base_q - IW'(1);
                base_d  = w;
                state_d = phbw_pkg::ST_REC_CLR;
              end
            end else if ({1'b0, w} >= top_q) begin
              k_d     = start_word;
              kend_d  = w;
              base_d  = new_base;
              top_d   = wp1;
              state_d = phbw_pkg::ST_REC_CLR;
            end else begin
              state_d = phbw_pkg::ST_REC_RD;
            end
          end
          phbw_pkg::OP_ADVANCE: begin
            if (w > base_q) begin
              base_d = w;
              if (top_q < {1'b0, w}) begin
                top_d = {1'b0, w};
              end
            end
            if (lowest_q < height_q) begin
              lowest_d = height_q;
            end
            if (highest_q < height_q) begin
              highest_d = height_q;
            end
            strobe_d = 1'b1;
            state_d  = phbw_pkg::ST_IDLE;
          end
          phbw_pkg::OP_QUERY: begin
            if (height_q > highest_q || height_q < lowest_q || !probe.in_win) begin
              strobe_d = 1'b1;
              state_d  = phbw_pkg::ST_IDLE;
            end else begin
              state_d = phbw_pkg::ST_QRY_RD;
            end
          end
          default: begin
            if (highest_q == '0 || highest_q == lowest_q ||
                (highest_q - HW'(1)) < floor_c) begin
              strobe_d = 1'b1;
              state_d  = phbw_pkg::ST_IDLE;
            end else begin
              pos_d         = highest_q - HW'(1);
              floor_d       = floor_c;
              phase2_d      = 1'b0;
              cnt_d         = '0;
              cache_valid_d = 1'b0;
              state_d       = phbw_pkg::ST_GAP;
            end
          end
        endcase
      end

      phbw_pkg::ST_REC_CLR: begin
        k_d = k_q + IW'(1);
        if (k_q == kend_q) begin
          state_d = phbw_pkg::ST_REC_RD;
        end
      end

      phbw_pkg::ST_REC_RD: begin
        state_d = phbw_pkg::ST_REC_WR;
      end

      phbw_pkg::ST_REC_WR: begin
        if (height_q > highest_q) begin
          highest_d = height_q;
        end
        if (height_q < lowest_q) begin
          lowest_d = height_q;
        end
        strobe_d = 1'b1;
        state_d  = phbw_pkg::ST_IDLE;
      end

      phbw_pkg::ST_QRY_RD: begin
        recorded_d = ram_rdata[height_q[5:0]];
        strobe_d   = 1'b1;
        state_d    = phbw_pkg::ST_IDLE;
      end

      phbw_pkg::ST_GAP: begin
        if (stop_gap) begin
          // The run has reached max_gap; no bit is needed.
          found_d     = 1'b1;
          left_d      = pos_q + HW'(1);
          right_out_d = right_q;
          strobe_d    = 1'b1;
          state_d     = phbw_pkg::ST_IDLE;
        end else if (probe.in_win && !probe.hit) begin
          state_d = phbw_pkg::ST_GAP_FILL;
        end else if (!phase2_q) begin
          if (!bit_now) begin
            right_d = pos_q;
            if (pos_q == floor_q) begin
              found_d     = 1'b1;
              left_d      = floor_q;
              right_out_d = pos_q;
              strobe_d    = 1'b1;
              state_d     = phbw_pkg::ST_IDLE;
            end else begin
              pos_d    = pos_q - HW'(1);
              cnt_d    = phbw_pkg::CNT_W'(1);
              phase2_d = 1'b1;
            end
          end else if (pos_q == floor_q) begin
            strobe_d = 1'b1;
            state_d  = phbw_pkg::ST_IDLE;
          end else begin
            pos_d = pos_q - HW'(1);
          end
        end else begin
          if (bit_now) begin
            found_d     = 1'b1;
            left_d      = pos_q + HW'(1);
            right_out_d = right_q;
            strobe_d    = 1'b1;
            state_d     = phbw_pkg::ST_IDLE;
          end else if (pos_q == floor_q) begin
            found_d     = 1'b1;
            left_d      = floor_q;
            right_out_d = right_q;
            strobe_d    = 1'b1;
            state_d     = phbw_pkg::ST_IDLE;
          end else begin
            pos_d = pos_q - HW'(1);
            cnt_d = cnt_q + phbw_pkg::CNT_W'(1);
          end
        end
      end

      phbw_pkg::ST_GAP_FILL: begin
        cache_valid_d = 1'b1;
        cache_tag_d   = pos_q[HW-1:6];
        cache_word_d  = ram_rdata;
        state_d       = phbw_pkg::ST_GAP;
      end

      default: begin
        state_d = phbw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= phbw_pkg::ST_CLR;
      base_q        <= '0;
      top_q         <= '0;
      lowest_q      <= '0;
      highest_q     <= '0;
      clr_q         <= '0;
      strobe_q      <= 1'b0;
      cache_valid_q <= 1'b0;
      phase2_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      base_q        <= base_d;
      top_q         <= top_d;
      lowest_q      <= lowest_d;
      highest_q     <= highest_d;
      clr_q         <= clr_d;
      strobe_q      <= strobe_d;
      cache_valid_q <= cache_valid_d;
      phase2_q      <= phase2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    height_q     <= height_d;
    max_gap_q    <= max_gap_d;
    k_q          <= k_d;
    kend_q       <= kend_d;
    pos_q        <= pos_d;
    floor_q      <= floor_d;
    right_q      <= right_d;
    cnt_q        <= cnt_d;
    cache_tag_q  <= cache_tag_d;
    cache_word_q <= cache_word_d;
    recorded_q   <= recorded_d;
    found_q      <= found_d;
    left_q       <= left_d;
    right_out_q  <= right_out_d;
    overflow_q   <= overflow_d;
  end

  assign busy_o     = (state_q != phbw_pkg::ST_IDLE);
  assign strobe_o   = strobe_q;
  assign recorded_o = recorded_q;
  assign found_o    = found_q;
  assign gap_lo_o   = left_q;
  assign gap_hi_o   = right_out_q;
  assign overflow_o = overflow_q;

`ifndef SYNTH
  // Result beats never come back to back.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o) else $error("back-to-back result beats");

  // The window never inverts.
  a_base_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, base_q} <= top_q) else $error("window base above top");

  // The window never holds more words than the RAM is sized for.
  a_win_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q - {1'b0, base_q}) <= WIN) else $error("window exceeds capacity");

  // A found gap is an ordered range.
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && found_o) |-> (gap_lo_o <= gap_hi_o))
    else $error("gap ends out of order");

  // A refused record never reports a gap.
  a_ovf_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !(overflow_o && found_o)) else $error("overflow with gap");
`endif

endmodule

// ===== tb/tb_processed_height_bitmap_window.sv =====
// Self-checking testbench for the processed-height bitmap window tracker.
`timescale 1ns / 100ps

// The testbench runs in three parts:
//  - A short table of directed commands. Rows whose result is plain to see
//    (after reset, extremes, refused records) carry a typed-in expectation.
//    Every other row is checked against the tracker model below.
//  - Random commands near the current window, checked against the same model.
//  - A few records, queries and searches at the top of the height range.
//
// Each accepted command beat yields exactly one result beat. The result beat
// is shown for one cycle with strobe_o high. The model is updated in command
// order, and result beats are matched against a FIFO of expected results.
module tb_processed_height_bitmap_window;

  localparam int unsigned NUM_RANDOM = 1450;
  localparam int unsigned STALL_LIMIT = 300000;
  localparam logic [63:0] MAX_H = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        rec;
    logic        fnd;
    logic [63:0] left_h;
    logic [63:0] right_h;
    logic        ovf;
  } beat_t;

  typedef struct {
    phbw_pkg::op_e op;
    logic [63:0]   height;
    logic [15:0]   max_gap;
    bit            typed;
    beat_t         want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [63:0] height_i;
  logic [15:0] max_gap_i;
  logic        strobe_o;
  logic        recorded_o;
  logic        found_o;
  logic [63:0] gap_lo_o;
  logic [63:0] gap_hi_o;
  logic        overflow_o;

  // Tracker model: a copy of the window, its bounds and the recorded extremes.
  logic [63:0] bm_words [64];
  logic [63:0] base_word;
  logic [63:0] top_word;
  logic [63:0] low_rec;
  logic [63:0] high_rec;

  beat_t       pending_beats[$];
  bit          failed;
  int unsigned idle_cycles;
  int unsigned idle_pct;

  processed_height_bitmap_window u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .op_i       (op_i),
    .height_i   (height_i),
    .max_gap_i  (max_gap_i),
    .strobe_o   (strobe_o),
    .recorded_o (recorded_o),
    .found_o    (found_o),
    .gap_lo_o   (gap_lo_o),
    .gap_hi_o   (gap_hi_o),
    .overflow_o (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Heights outside the window read as zero.
  function automatic logic bit_at(logic [63:0] h);
    logic [63:0] w;
    w = h >> 6;
    if (w < base_word || w >= top_word) return 1'b0;
    return bm_words[w[5:0]][h[5:0]];
  endfunction

  // Applies one command to the tracker model and returns the result it causes.
  task automatic track_cmd(input phbw_pkg::op_e op, input logic [63:0] h,
                           input logic [15:0] gap, output beat_t res);
    logic [63:0] w;
    logic [63:0] nb;
    logic [63:0] first;
    logic [63:0] flr;
    logic [63:0] scan;
    logic [63:0] right_h;
    res = '{1'b0, 1'b0, 64'd0, 64'd0, 1'b0};
    w = h >> 6;
    case (op)
      phbw_pkg::OP_RECORD: begin
        if (w < base_word) begin
          // Growing down is refused once the window would exceed its capacity.
          if (top_word - w > 64) begin
            res.ovf = 1'b1;
          end else begin
            for (logic [63:0] k = w; k < base_word; k++) bm_words[k[5:0]] = '0;
            base_word = w;
          end
        end else if (w + 1 > top_word) begin
          // Growing up slides the base so that at most 64 words stay.
          nb = base_word;
          if (w + 1 - base_word > 64) nb = w + 1 - 64;
          first = (top_word > nb) ? top_word : nb;
          for (logic [63:0] k = first; k < w + 1; k++) bm_words[k[5:0]] = '0;
          base_word = nb;
          top_word = w + 1;
        end
        if (!res.ovf) begin
          bm_words[w[5:0]][h[5:0]] = 1'b1;
          if (h > high_rec) high_rec = h;
          if (h < low_rec) low_rec = h;
        end
      end
      phbw_pkg::OP_ADVANCE: begin
        if (w > base_word) begin
          base_word = w;
          if (top_word < w) top_word = w;
        end
        if (low_rec < h) low_rec = h;
        if (high_rec < h) high_rec = h;
      end
      phbw_pkg::OP_QUERY: begin
        if (h <= high_rec && h >= low_rec) res.rec = bit_at(h);
      end
      default: begin
        // Latest gap: skip the recorded run below the highest height, then
        // extend the missing run down until a set bit, max_gap or the floor.
        if (high_rec != 0 && high_rec != low_rec) begin
          flr = (low_rec > 1) ? low_rec : 64'd1;
          if (high_rec - 1 >= flr) begin
            scan = high_rec - 1;
            while (bit_at(scan) && scan != flr) scan--;
            if (!bit_at(scan)) begin
              right_h = scan;
              res.fnd = 1'b1;
              res.right_h = right_h;
              res.left_h = flr;
              while (scan > flr) begin
                scan--;
                if (right_h - scan >= gap || bit_at(scan)) begin
                  res.left_h = scan + 1;
                  break;
                end
              end
            end
          end
        end
      end
    endcase
  endtask

  // Drives one command beat, waits for it to be taken, then maybe idles.
  task automatic issue(input phbw_pkg::op_e op, input logic [63:0] h,
                       input logic [15:0] gap, input bit typed, input beat_t want);
    beat_t res;
    start_i   <= 1'b1;
    op_i      <= op;
    height_i  <= h;
    max_gap_i <= gap;
    do @(posedge clk_i); while (busy_o);
    track_cmd(op, h, gap, res);
    pending_beats.insert(pending_beats.size(), typed ? want : res);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Result checker: every strobe must match the oldest expected beat.
  always @(posedge clk_i) begin
    beat_t exp_b;
    if (rst_ni && strobe_o) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no command pending");
        failed = 1'b1;
      end else begin
        exp_b = pending_beats.pop_front();
        if (recorded_o !== exp_b.rec) begin
          $error("recorded: expected %0d, got %0d", exp_b.rec, recorded_o);
          failed = 1'b1;
        end
        if (found_o !== exp_b.fnd) begin
          $error("found: expected %0d, got %0d", exp_b.fnd, found_o);
          failed = 1'b1;
        end
        if (gap_lo_o !== exp_b.left_h) begin
          $error("gap_lo: expected %0d, got %0d", exp_b.left_h, gap_lo_o);
          failed = 1'b1;
        end
        if (gap_hi_o !== exp_b.right_h) begin
          $error("gap_hi: expected %0d, got %0d", exp_b.right_h, gap_hi_o);
          failed = 1'b1;
        end
        if (overflow_o !== exp_b.ovf) begin
          $error("overflow: expected %0d, got %0d", exp_b.ovf, overflow_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any beat moving.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || strobe_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t      dir_tbl[$];
    beat_t         zero_b;
    beat_t         b;
    phbw_pkg::op_e op;
    logic [63:0]   h;
    logic [63:0]   w;
    logic [63:0]   lo_w;
    logic [15:0]   gap;
    int unsigned   pick;

    zero_b = '{1'b0, 1'b0, 64'd0, 64'd0, 1'b0};
    failed = 1'b0;
    idle_pct = 0;
    idle_cycles = 0;
    for (int i = 0; i < 64; i++) bm_words[i] = '0;
    base_word = '0;
    top_word = '0;
    low_rec = '0;
    high_rec = '0;

    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    op_i      <= phbw_pkg::OP_RECORD;
    height_i  <= '0;
    max_gap_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. The window starts empty, so reads after reset are zero.
    b = zero_b;
    b.rec = 1'b1;
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_QUERY,  64'd0,    16'd0, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    64'd0,    16'd5, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd0,    16'd0, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd100,  16'd0, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd130,  16'd0, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_QUERY,  64'd100,  16'd0, 1, b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_QUERY,  64'd101,  16'd0, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    64'd0,    16'd0, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    64'd0,    16'd1, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    MAX_H, 16'hFFFF, 0, zero_b});
    // A height above the highest record reads as zero.
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_QUERY,  MAX_H,    16'd0, 1, zero_b});
    // This record slides the window up past the first words.
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd4483, 16'd0, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_QUERY,  64'd100,  16'd0, 0, zero_b});
    // Growing down past capacity is refused.
    b = zero_b;
    b.ovf = 1'b1;
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd5,    16'd0, 1, b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd448,  16'd0, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_ADVANCE, 64'd642, 16'd0, 0, zero_b});
    // Below the lowest record after the floor moved up.
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_QUERY,  64'd600,  16'd0, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    64'd0,   16'd20, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd4484, 16'd0, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_ADVANCE, 64'd4484, 16'd0, 0, zero_b});
    // Lowest equals highest: nothing to search.
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    64'd0,    16'd9, 1, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_RECORD, 64'd4490, 16'd0, 0, zero_b});
    dir_tbl.insert(dir_tbl.size(), '{phbw_pkg::OP_GAP,    64'd0,    16'd3, 0, zero_b});
    foreach (dir_tbl[i]) begin
      issue(dir_tbl[i].op, dir_tbl[i].height, dir_tbl[i].max_gap,
            dir_tbl[i].typed, dir_tbl[i].want);
    end

    // Random part. Four phases of sender pacing: none, heavy, none, light.
    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      case (n * 4 / NUM_RANDOM)
        1: idle_pct = 68;
        3: idle_pct = 10;
        default: idle_pct = 0;
      endcase
      pick = $urandom_range(99);
      lo_w = (top_word > 50) ? top_word - 50 : 64'd0;
      gap = ($urandom_range(99) == 0) ? 16'hFFFF : 16'($urandom_range(0, 300));
      h = {$urandom, $urandom};
      if (pick < 45) begin
        op = phbw_pkg::OP_RECORD;
        // Mostly inside or just above the window; now and then far above or
        // far below it.
        case ($urandom_range(99))
          0, 1, 2: w = top_word + $urandom_range(2, 200);
          3, 4:    w = $urandom_range(0, 3);
          default: w = lo_w + $urandom_range(0, 52);
        endcase
        h = {w[57:0], h[5:0]};
      end else if (pick < 70) begin
        op = phbw_pkg::OP_QUERY;
        if ($urandom_range(9) != 0) h = (high_rec > 3000) ?
            high_rec - $urandom_range(0, 3000) : 64'($urandom_range(0, 3000));
      end else if (pick < 90) begin
        op = phbw_pkg::OP_GAP;
      end else begin
        op = phbw_pkg::OP_ADVANCE;
        h = (base_word << 6) + $urandom_range(0, 160);
      end
      issue(op, h, gap, 1'b0, zero_b);
    end

    // Top of the height range last, since it moves the window for good.
    idle_pct = 0;
    issue(phbw_pkg::OP_RECORD,  MAX_H - 64'd70, 16'd0, 1'b0, zero_b);
    issue(phbw_pkg::OP_RECORD,  MAX_H,          16'd0, 1'b0, zero_b);
    issue(phbw_pkg::OP_QUERY,   MAX_H,          16'd0, 1'b0, zero_b);
    issue(phbw_pkg::OP_GAP,     64'd0,          16'd5, 1'b0, zero_b);
    issue(phbw_pkg::OP_ADVANCE, MAX_H,          16'd0, 1'b0, zero_b);
    issue(phbw_pkg::OP_GAP,     64'd0,          16'd5, 1'b0, zero_b);
    start_i <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (failed || pending_beats.size() != 0) begin
      $display("RESULT: ERROR");
    end else begin
      $display("RESULT: OK");
    end
    $finish;
  end

endmodule

// ===== processed_height_bitmap_window.f =====
hdl/phbw_pkg.sv
hdl/phbw_ram.sv
hdl/phbw_probe.sv
hdl/processed_height_bitmap_window.sv
tb/tb_processed_height_bitmap_window.sv
